/* hdl/sid_pkg.sv */
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the signed integer to decimal digit emitter.
// ----------------------------------------------------------------------------
package sid_pkg;

  // Magnitude width: the largest magnitude, 2**31, fits in 32 unsigned bits.
  localparam int MAG_W      = 32;
  // A 32-bit magnitude has at most ten decimal digits.
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  // Bit counter for the conversion, holds 0..MAG_W.
  localparam int BITCNT_W   = $clog2(MAG_W + 1);
  // Digit counters, hold 0..BCD_DIGITS.
  localparam int DCNT_W     = 5;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         digit_limit;
  } in_t;

  typedef struct packed {
    logic       is_minus;
    logic [3:0] digit;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

endpackage

/* hdl/sid_dabble.sv */
// ----------------------------------------------------------------------------
// sid_dabble
// Bit-serial binary to BCD converter: shifts one magnitude bit per cycle into
// a ten-digit BCD register, with the add-three correction on each digit.
// ----------------------------------------------------------------------------
module sid_dabble (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sid_pkg::MAG_W-1:0] mag,
  output logic                      done,
  output logic [sid_pkg::BCD_W-1:0] bcd
);

  logic [sid_pkg::MAG_W-1:0]    mag_r, mag_nxt;
  logic [sid_pkg::BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [sid_pkg::BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [sid_pkg::BCD_W-1:0]    adj;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < sid_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // While counting, one magnitude bit moves into the BCD register each cycle.
  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = sid_pkg::BITCNT_W'(sid_pkg::MAG_W);
    end else if (cnt_r != '0) begin
      bcd_nxt  = {adj[sid_pkg::BCD_W-2:0], mag_r[sid_pkg::MAG_W-1]};
      mag_nxt  = {mag_r[sid_pkg::MAG_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == sid_pkg::BITCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

  // The finish pulse comes only once the final bit is in and no bits are left.
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == '0)
    else $error("conversion finished with bits left");

  // A start is never issued while a conversion is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    start |-> cnt_r == '0)
    else $error("conversion restarted while busy");

  // The counter moves down by one per cycle while busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !start) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("bit counter skipped");

endmodule

/* hdl/sid_emit.sv */
// ----------------------------------------------------------------------------
// sid_emit
// Digit emitter: drops leading zeros one per cycle, then a minus if negative
// and the kept digits go out most significant first via an output register.
// ----------------------------------------------------------------------------
module sid_emit #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sid_pkg::BCD_W-1:0] bcd,
  input  logic                      neg,
  input  logic [3:0]                limit,
  output logic                      done,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sid_pkg::out_t             out_data
);

  localparam logic [sid_pkg::DCNT_W-1:0] CAP = sid_pkg::DCNT_W'(MAX_DIGITS);

  logic [sid_pkg::BCD_W-1:0]  dig_r, dig_nxt;
  logic [sid_pkg::DCNT_W-1:0] ndig_r, ndig_nxt;
  logic [sid_pkg::DCNT_W-1:0] left_r, left_nxt;
  logic [3:0]                 lim_r, lim_nxt;
  logic                       neg_r, neg_nxt;
  logic                       skip_r, skip_nxt;
  logic                       done_r, done_nxt;
  logic                       oval_r, oval_nxt;
  sid_pkg::out_t              odat_r, odat_nxt;
  logic [sid_pkg::DCNT_W-1:0] count;
  logic                       slot;
  logic [3:0]                 top_dig;

  assign top_dig = dig_r[sid_pkg::BCD_W-1 -: 4];
  assign slot    = !oval_r || out_ready;

  // Number of digits to send once the leading zeros are gone.
  always_comb begin
    count = ndig_r;
    if (lim_r != 4'd0 && {1'b0, lim_r} < ndig_r) begin
      count = {1'b0, lim_r};
    end
    if (count > CAP) begin
      count = CAP;
    end
  end

  // Skip phase, then one request per free output slot.
  always_comb begin
    dig_nxt  = dig_r;
    ndig_nxt = ndig_r;
    left_nxt = left_r;
    lim_nxt  = lim_r;
    neg_nxt  = neg_r;
    skip_nxt = skip_r;
    done_nxt = 1'b0;
    oval_nxt = oval_r && !out_ready;
    odat_nxt = odat_r;
    if (start) begin
      dig_nxt  = bcd;
      ndig_nxt = sid_pkg::DCNT_W'(sid_pkg::BCD_DIGITS);
      lim_nxt  = limit;
      neg_nxt  = neg;
      skip_nxt = 1'b1;
    end else if (skip_r) begin
      if (top_dig == 4'd0 && ndig_r > sid_pkg::DCNT_W'(1)) begin
        dig_nxt  = {dig_r[sid_pkg::BCD_W-5:0], 4'd0};
        ndig_nxt = ndig_r - 1'b1;
      end else begin
        skip_nxt = 1'b0;
        left_nxt = count;
      end
    end else if (left_r != '0 && slot) begin
      oval_nxt = 1'b1;
      if (neg_r) begin
        neg_nxt           = 1'b0;
        odat_nxt.is_minus = 1'b1;
        odat_nxt.digit    = 4'd0;
        odat_nxt.last     = 1'b0;
      end else begin
        odat_nxt.is_minus = 1'b0;
        odat_nxt.digit    = top_dig;
        odat_nxt.last     = (left_r == sid_pkg::DCNT_W'(1));
        dig_nxt           = {dig_r[sid_pkg::BCD_W-5:0], 4'd0};
        left_nxt          = left_r - 1'b1;
        done_nxt          = (left_r == sid_pkg::DCNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      skip_r <= 1'b0;
      done_r <= 1'b0;
      oval_r <= 1'b0;
      neg_r  <= 1'b0;
    end else begin
      left_r <= left_nxt;
      skip_r <= skip_nxt;
      done_r <= done_nxt;
      oval_r <= oval_nxt;
      neg_r  <= neg_nxt;
    end
    dig_r  <= dig_nxt;
    ndig_r <= ndig_nxt;
    lim_r  <= lim_nxt;
    odat_r <= odat_nxt;
  end

  assign done      = done_r;
  assign out_valid = oval_r;
  assign out_data  = odat_r;

  // A minus request is never the final one and carries a zero digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && odat_r.is_minus) |-> (!odat_r.last && odat_r.digit == 4'd0))
    else $error("malformed minus request");

  // Completion is signaled together with a fresh final request.
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (oval_r && odat_r.last))
    else $error("completion without final request");

  // Skipping and sending never overlap.
  assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> left_r == '0)
    else $error("skip phase overlaps sending");

endmodule

/* hdl/signed_int_to_decimal_digits.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_digits
// Converts a signed 32-bit integer to a run of decimal digit requests.
// ----------------------------------------------------------------------------
// Each input request carries a 32-bit two's complement value and a digit
// limit. The block answers with a minus request for a negative value, then
// the decimal digits most significant first, leading zeros dropped, the
// final one flagged by last. A nonzero limit below the digit count keeps
// only that many leading digits; no more than MAX_DIGITS digits are sent.
// One request is handled at a time: bit-serial binary to BCD conversion,
// a hand-over of the digits to the emitter, dropping of leading zeros, then
// one result request per cycle sent (up to 11) while the output is not
// stalled; a stalled result holds the sending. A new input is taken while
// the final result still waits in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_digits #(
  parameter int MAX_DIGITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sid_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sid_pkg::out_t  out_data
);

  sid_pkg::state_t           state_r, state_nxt;
  logic                      neg_r, neg_nxt;
  logic [3:0]                lim_r, lim_nxt;
  logic                      in_fire;
  logic [sid_pkg::MAG_W-1:0] mag;
  logic                      conv_done;
  logic [sid_pkg::BCD_W-1:0] bcd;
  logic                      emit_done;

  assign in_fire = in_valid && in_ready;

  // Magnitude of the value; the most negative value maps to 2**31.
  always_comb begin
    if (in_data.value[31]) begin
      mag = 32'(-in_data.value);
    end else begin
      mag = 32'(in_data.value);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sid_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = sid_pkg::ST_CONV;
      end
      sid_pkg::ST_CONV: begin
        if (conv_done) state_nxt = sid_pkg::ST_EMIT;
      end
      sid_pkg::ST_EMIT: begin
        if (emit_done) state_nxt = sid_pkg::ST_IDLE;
      end
      default: state_nxt = sid_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer and capture of the request's side fields.
  always_comb begin
    in_ready = (state_r == sid_pkg::ST_IDLE);
    neg_nxt  = neg_r;
    lim_nxt  = lim_r;
    if (in_fire) begin
      neg_nxt = in_data.value[31];
      lim_nxt = in_data.digit_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    neg_r <= neg_nxt;
    lim_r <= lim_nxt;
  end

  sid_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  sid_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (conv_done),
    .bcd       (bcd),
    .neg       (neg_r),
    .limit     (lim_r),
    .done      (emit_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An accepted request starts a conversion.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == sid_pkg::ST_CONV)
    else $error("accepted request did not start conversion");

  // The conversion finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> state_r == sid_pkg::ST_CONV)
    else $error("conversion finished out of sequence");

  // Digit sending completes only in the sending state.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_done |-> state_r == sid_pkg::ST_EMIT)
    else $error("sending finished out of sequence");

endmodule

/* verif/digit_run_checker.sv */
// ----------------------------------------------------------------------------
// digit_run_checker
// Watches both request channels of the decimal digit emitter and checks them.
// ----------------------------------------------------------------------------
// Every accepted input request is expanded into the digit run it must cause:
// an optional minus request, then the leading digits of the 33-bit
// magnitude, cut to the digit limit and the digit cap. Each accepted output
// request is compared field by field against the oldest expected one. The
// failure count and the number of requests still outstanding go to the top.
// ----------------------------------------------------------------------------
module digit_run_checker #(
  parameter int MAX_DIGITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  sid_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  sid_pkg::out_t out_data,
  output int            fail_count,
  output int            outstanding
);

  // Digit requests still owed by the block, oldest first.
  sid_pkg::out_t expected_digits[$];

  // Expands one input request into the digit run it must produce.
  function automatic void queue_decimal_digits(input sid_pkg::in_t req);
    logic [32:0]   mag;
    logic [3:0]    rev [20];
    int            ndig;
    int            count;
    sid_pkg::out_t item;
    ndig = 0;
    // The magnitude is taken at 33 bits so the most negative value works.
    if (req.value[31]) begin
      mag = 33'h1_0000_0000 - {1'b0, req.value};
    end else begin
      mag = {1'b0, req.value};
    end
    if (mag == 0) begin
      rev[0] = 4'd0;
      ndig = 1;
    end
    // Collect digits least significant first.
    while (mag != 0 && ndig < 20) begin
      rev[ndig] = 4'(mag % 33'd10);
      mag = mag / 33'd10;
      ndig++;
    end
    // A nonzero limit below the digit count keeps only the leading digits.
    count = ndig;
    if (req.value != 0 && req.digit_limit != 0 && int'(req.digit_limit) < count) begin
      count = int'(req.digit_limit);
    end
    if (count > MAX_DIGITS) begin
      count = MAX_DIGITS;
    end
    if (count < 1) begin
      count = 1;
    end
    // A negative value starts with a minus request that never ends the run.
    if (req.value[31]) begin
      item = '{is_minus: 1'b1, digit: 4'd0, last: 1'b0};
      expected_digits.push_back(item);
    end
    for (int i = 0; i < count; i++) begin
      item.is_minus = 1'b0;
      item.digit    = rev[ndig - 1 - i];
      item.last     = (i == count - 1);
      expected_digits.push_back(item);
    end
  endfunction

  // Sample both channels at the rising edge.
  always @(posedge clk) begin : watch
    sid_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        queue_decimal_digits(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected result request: is_minus %0d digit %0d last %0d",
                 out_data.is_minus, out_data.digit, out_data.last);
          fail_count++;
        end else begin
          want = expected_digits.pop_front();
          if (out_data.is_minus !== want.is_minus) begin
            $error("field is_minus: expected %0d, actual %0d", want.is_minus,
                   out_data.is_minus);
            fail_count++;
          end
          if (out_data.digit !== want.digit) begin
            $error("field digit: expected %0d, actual %0d", want.digit, out_data.digit);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("field last: expected %0d, actual %0d", want.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_digits.size();
  end

endmodule

/* verif/signed_int_to_decimal_digits_tb.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_digits_tb
// Directed and random test of the signed integer to decimal digit emitter.
// ----------------------------------------------------------------------------
// A directed set covers zero, the extreme values, every kind of digit limit
// and alternating bit patterns. Random requests follow in four phases of
// sender idling and receiver stalls; between phases the sender waits until
// every expected digit has come back. The checker beside the block does
// the prediction and comparison; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_digits_tb;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 62;
  localparam int DIRECTED_COUNT   = 24;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  sid_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  sid_pkg::out_t out_data;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  always #5 clk = ~clk;

  signed_int_to_decimal_digits u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  digit_run_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver stalls at random at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL signed_int_to_decimal_digits");
      $finish;
    end
  end

  // Offers one input request after a random idle gap and waits for it.
  task automatic send_request(input logic signed [31:0] value, input logic [3:0] limit);
    int           gap;
    sid_pkg::in_t req;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.value       = value;
    req.digit_limit = limit;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds the sender off until every expected digit has arrived.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) begin
      @(negedge clk);
    end
  endtask

  // Mostly values of a random digit count, some full-width, a few extremes.
  function automatic logic signed [31:0] random_value();
    int              pick;
    int              ndig;
    logic [63:0]     bound;
    logic [63:0]     mag;
    logic            neg;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      return $urandom;
    end
    if (pick < 42) begin
      case ($urandom_range(0, 3))
        0: return 32'sh0000_0000;
        1: return 32'sh8000_0000;
        2: return 32'sh7FFF_FFFF;
        default: return -32'sd1;
      endcase
    end
    neg = $urandom_range(0, 1);
    ndig = $urandom_range(1, 10);
    bound = 64'd1;
    repeat (ndig) bound = bound * 64'd10;
    mag = {$urandom, $urandom} % bound;
    if (neg && mag > 64'h8000_0000) begin
      mag = mag % 64'h8000_0001;
    end else if (!neg && mag > 64'h7FFF_FFFF) begin
      mag = mag % 64'h8000_0000;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  // Limit zero is favored; every code up to 15 is used.
  function automatic logic [3:0] random_limit();
    if ($urandom_range(0, 99) < 20) begin
      return 4'd0;
    end
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin : stimulus
    logic signed [31:0] dir_values [DIRECTED_COUNT];
    logic [3:0]         dir_limits [DIRECTED_COUNT];
    dir_values = '{32'sd0, 32'sd0, 32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF,
                   32'sh8000_0000, 32'sh8000_0000, 32'sd1234567890, 32'sd1234567890,
                   32'sd1234567890, 32'sd1234567890, -32'sd9, 32'sd1000000000,
                   32'sd99, -32'sd100, 32'sh5555_5555, 32'shAAAA_AAAA,
                   32'sd10, -32'sd1234567890, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sd1000000000, -32'sd2};
    dir_limits = '{4'd0, 4'd5, 4'd15, 4'd0, 4'd0, 4'd0,
                   4'd0, 4'd1, 4'd3, 4'd10, 4'd11, 4'd15,
                   4'd1, 4'd2, 4'd1, 4'd2, 4'd0, 4'd0,
                   4'd1, 4'd9, 4'd9, 4'd10, 4'd10, 4'd14};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests with no idling on either side.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_request(dir_values[i], dir_limits[i]);
    end
    wait_until_drained();

    // Random phases: none, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      repeat (RANDOM_PER_PHASE) send_request(random_value(), random_limit());
      wait_until_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS signed_int_to_decimal_digits");
    end else begin
      $display("FAIL signed_int_to_decimal_digits");
    end
    $finish;
  end

endmodule
